/* hw/rtl/bsfd_pkg.sv */
// Shared types and constants for the byte-stuffed frame deframer.
package bsfd_pkg;

  localparam int unsigned MaxFrameBytesDefault = 64;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] REG_END_CHAR    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_ESCAPE_CHAR = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_ESCAPE_MASK = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] END_CHAR_RESET    = 8'd126;
  localparam logic [7:0] ESCAPE_CHAR_RESET = 8'd125;
  localparam logic [7:0] ESCAPE_MASK_RESET = 8'd32;

  typedef logic [1:0] frame_status_t;

  localparam frame_status_t ST_GOOD     = 2'd0;
  localparam frame_status_t ST_CRC      = 2'd1;
  localparam frame_status_t ST_OVERFLOW = 2'd2;
  localparam frame_status_t ST_EMPTY    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STATUS,
    S_DRAIN
  } state_t;

endpackage

/* hw/rtl/byte_stuffed_frame_deframer.sv */
// Byte-stuffed frame deframer with XOR checksum check, one frame buffer in RAM.
// Status item registered from the status state after the closing byte; good bytes
// read from the buffer, then registered. One raw byte per cycle while collecting;
// closing a frame holds off input for its status or its drain, plus output stalls.
// Reset (rst, synchronous): frame cleared, registers to 126 / 125 / 32; buffer
// contents are left as they are and are only read after being written.
module byte_stuffed_frame_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = bsfd_pkg::MaxFrameBytesDefault
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_write,
  input  logic [bsfd_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [bsfd_pkg::CfgDataWidth-1:0]     cfg_data,
  // raw link bytes
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_byte,
  // decoded items
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            out_byte,
  output logic                                  frame_last,
  output bsfd_pkg::frame_status_t               frame_status
);

  import bsfd_pkg::*;

  // Buffer holds at most MAX_FRAME_BYTES-1 decoded bytes: a frame that
  // reaches the raw limit without an end byte is flushed.
  localparam int unsigned Depth = MAX_FRAME_BYTES - 1;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned RawW  = $clog2(MAX_FRAME_BYTES + 1);

  // configuration
  logic [7:0] end_char;
  logic [7:0] escape_char;
  logic [7:0] escape_xor_mask;

  // frame state
  state_t        state, state_next;
  logic [RawW-1:0] raw_count, raw_count_next;
  logic          escape_pending, escape_pending_next;
  logic [CntW-1:0] decoded_count, decoded_count_next;
  logic [7:0]    running_xor, running_xor_next;

  // drain / status control
  logic [CntW-1:0] drain_len, drain_len_next;
  logic [CntW-1:0] rd_idx, rd_idx_next;
  logic          rd_pending, rd_pending_next;
  frame_status_t pend_status, pend_status_next;

  // output register
  logic          out_valid_next;
  logic [7:0]    out_byte_next;
  logic          frame_last_next;
  frame_status_t frame_status_next;

  // decoded byte buffer
  logic [7:0]    decoded_store [Depth];
  logic          mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [7:0]    rd_q;

  // input decode
  logic          can_load;
  logic          is_end;
  logic [7:0]    esc_byte;
  logic          room;
  logic          append;
  logic [7:0]    store_byte;
  logic [CntW-1:0] cnt_after;
  logic [7:0]    xor_after;

  assign in_stall = (state != S_IDLE);
  assign can_load = !out_valid || !out_stall;
  assign esc_byte = in_byte ^ escape_xor_mask;
  assign is_end   = (in_byte == end_char);
  assign room     = (decoded_count < CntW'(Depth));

  always_ff @(posedge clk) begin
    if (rst) begin
      end_char        <= END_CHAR_RESET;
      escape_char     <= ESCAPE_CHAR_RESET;
      escape_xor_mask <= ESCAPE_MASK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_END_CHAR:    end_char        <= cfg_data;
        REG_ESCAPE_CHAR: escape_char     <= cfg_data;
        REG_ESCAPE_MASK: escape_xor_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoded byte buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      decoded_store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= decoded_store[rd_idx[AddrW-1:0]];
    end
  end

  always_comb begin
    state_next          = state;
    raw_count_next      = raw_count;
    escape_pending_next = escape_pending;
    decoded_count_next  = decoded_count;
    running_xor_next    = running_xor;
    drain_len_next      = drain_len;
    rd_idx_next         = rd_idx;
    rd_pending_next     = rd_pending;
    pend_status_next    = pend_status;

    out_valid_next      = out_valid && out_stall;
    out_byte_next       = out_byte;
    frame_last_next     = frame_last;
    frame_status_next   = frame_status;

    mem_we     = 1'b0;
    mem_waddr  = decoded_count[AddrW-1:0];
    mem_wdata  = in_byte;
    mem_re     = 1'b0;

    append     = 1'b0;
    store_byte = in_byte;
    cnt_after  = decoded_count;
    xor_after  = running_xor;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          raw_count_next = raw_count + RawW'(1);
          if (is_end) begin
            // escape right before the end byte: the end byte is kept, masked
            append     = escape_pending && room;
            store_byte = esc_byte;
            cnt_after  = decoded_count + CntW'(append);
            xor_after  = running_xor ^ (append ? esc_byte : 8'd0);
            mem_we     = append;
            mem_wdata  = esc_byte;
            raw_count_next      = '0;
            escape_pending_next = 1'b0;
            decoded_count_next  = '0;
            running_xor_next    = '0;
            if (cnt_after == '0) begin
              pend_status_next = ST_EMPTY;
              state_next       = S_STATUS;
            end else if (xor_after != 8'd0) begin
              // XOR over all bytes including checksum must come out zero
              pend_status_next = ST_CRC;
              state_next       = S_STATUS;
            end else begin
              drain_len_next  = cnt_after;
              rd_idx_next     = '0;
              rd_pending_next = 1'b0;
              state_next      = S_DRAIN;
            end
          end else begin
            if (escape_pending) begin
              append              = 1'b1;
              store_byte          = esc_byte;
              escape_pending_next = 1'b0;
            end else if (in_byte == escape_char) begin
              escape_pending_next = 1'b1;
            end else begin
              append = 1'b1;
            end
            if (append && room) begin
              mem_we             = 1'b1;
              mem_wdata          = store_byte;
              decoded_count_next = decoded_count + CntW'(1);
              running_xor_next   = running_xor ^ store_byte;
            end
            if (raw_count == RawW'(MAX_FRAME_BYTES - 1)) begin
              raw_count_next      = '0;
              escape_pending_next = 1'b0;
              decoded_count_next  = '0;
              running_xor_next    = '0;
              pend_status_next    = ST_OVERFLOW;
              state_next          = S_STATUS;
            end
          end
        end
      end

      S_STATUS: begin
        if (can_load) begin
          out_valid_next    = 1'b1;
          out_byte_next     = 8'd0;
          frame_last_next   = 1'b1;
          frame_status_next = pend_status;
          state_next        = S_IDLE;
        end
      end

      S_DRAIN: begin
        if (rd_pending) begin
          if (can_load) begin
            out_valid_next    = 1'b1;
            out_byte_next     = rd_q;
            frame_last_next   = (rd_idx == drain_len);
            frame_status_next = ST_GOOD;
            if (rd_idx == drain_len) begin
              rd_pending_next = 1'b0;
              state_next      = S_IDLE;
            end else begin
              mem_re      = 1'b1;
              rd_idx_next = rd_idx + CntW'(1);
            end
          end
        end else begin
          mem_re          = 1'b1;
          rd_idx_next     = rd_idx + CntW'(1);
          rd_pending_next = 1'b1;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      raw_count      <= '0;
      escape_pending <= 1'b0;
      decoded_count  <= '0;
      running_xor    <= '0;
      rd_pending     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      raw_count      <= raw_count_next;
      escape_pending <= escape_pending_next;
      decoded_count  <= decoded_count_next;
      running_xor    <= running_xor_next;
      rd_pending     <= rd_pending_next;
      out_valid      <= out_valid_next;
    end
  end

  // payload and drain bookkeeping need no reset
  always_ff @(posedge clk) begin
    drain_len    <= drain_len_next;
    rd_idx       <= rd_idx_next;
    pend_status  <= pend_status_next;
    out_byte     <= out_byte_next;
    frame_last   <= frame_last_next;
    frame_status <= frame_status_next;
  end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the byte-stuffed frame deframer.
module testbench;
  import bsfd_pkg::*;

  localparam int unsigned MAX_FRAME   = MaxFrameBytesDefault;
  localparam int unsigned STORE_DEPTH = MAX_FRAME - 1;
  localparam int unsigned IDLE_LIMIT  = 3000;
  // index past the last register; writes to it must be ignored
  localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]    data;
    logic          last;
    frame_status_t status;
  } deframed_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;

  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [7:0]    in_byte  = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [7:0]    out_byte;
  logic          frame_last;
  frame_status_t frame_status;

  byte_stuffed_frame_deframer #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .frame_last  (frame_last),
    .frame_status(frame_status)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and the frame being collected
  // ---------------------------------------------------------------------------
  logic [7:0] cfg_end  = END_CHAR_RESET;
  logic [7:0] cfg_esc  = ESCAPE_CHAR_RESET;
  logic [7:0] cfg_mask = ESCAPE_MASK_RESET;

  logic [6:0] pr_raw  = '0;   // raw bytes taken in this frame
  logic       pr_pend = 1'b0; // escape seen, next byte gets the mask
  logic [7:0] pr_buf [STORE_DEPTH];
  logic [5:0] pr_len  = '0;   // decoded bytes held
  logic [7:0] pr_xor  = '0;   // xor of decoded bytes held

  deframed_item_t expected_items[$];

  int error_count  = 0;
  int result_count = 0;
  int sent_count   = 0;
  int gap_pct      = 0;   // chance of a sender gap before an item
  int stall_pct    = 0;   // chance of starting a receiver stall burst
  int stall_left   = 0;
  int idle_cycles  = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", result_count, what, got, want);
    error_count++;
  endtask

  task automatic push_status(input frame_status_t st);
    expected_items.push_back('{data: 8'h00, last: 1'b1, status: st});
  endtask

  task automatic keep_decoded(input logic [7:0] d);
    if (pr_len < STORE_DEPTH) begin
      pr_buf[pr_len] = d;
      pr_len++;
      pr_xor ^= d;
    end
  endtask

  task automatic clear_frame();
    pr_raw  = '0;
    pr_pend = 1'b0;
    pr_len  = '0;
    pr_xor  = '0;
  endtask

  // Advance the predictor by one accepted raw byte, queue what it causes.
  task automatic predict_deframe(input logic [7:0] b);
    int k;
    if (pr_raw < 7'd127) pr_raw++;
    if (b == cfg_end) begin
      // end byte closes even with an escape pending; the masked end is kept
      if (pr_pend) keep_decoded(b ^ cfg_mask);
      if (pr_len == 0) begin
        push_status(ST_EMPTY);
      end else if (pr_xor != 8'h00) begin
        push_status(ST_CRC);
      end else begin
        for (k = 0; k < pr_len; k++)
          expected_items.push_back('{data: pr_buf[k], last: (k == pr_len - 1),
                                     status: ST_GOOD});
      end
      clear_frame();
    end else begin
      if (pr_pend) begin
        // escape after escape lands here too: decoded, no new escape
        keep_decoded(b ^ cfg_mask);
        pr_pend = 1'b0;
      end else if (b == cfg_esc) begin
        pr_pend = 1'b1;
      end else begin
        keep_decoded(b);
      end
      if (pr_raw >= MAX_FRAME) begin
        clear_frame();
        push_status(ST_OVERFLOW);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one raw item, optional gap first, predicts at acceptance
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_deframe(b);
    sent_count++;
  endtask

  task automatic drain_results();
    while (expected_items.size() != 0) @(posedge clk);
  endtask

  // Registers only change with nothing in flight.
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [7:0] val);
    in_valid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk);   // let a byte with no result settle
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_END_CHAR:    cfg_end  = val;
      REG_ESCAPE_CHAR: cfg_esc  = val;
      REG_ESCAPE_MASK: cfg_mask = val;
      default: ;
    endcase
  endtask

  function automatic bit plain_ok(input logic [7:0] d);
    return (d != cfg_end) && (d != cfg_esc);
  endfunction

  function automatic bit escape_ok(input logic [7:0] d);
    return (cfg_esc != cfg_end) && ((d ^ cfg_mask) != cfg_end);
  endfunction

  // Put one decoded byte on the link, escaped when needed or by chance.
  task automatic send_decoded(input logic [7:0] d, input int esc_pct);
    if (escape_ok(d) && (!plain_ok(d) || $urandom_range(0, 99) < esc_pct)) begin
      send_byte(cfg_esc);
      send_byte(d ^ cfg_mask);
    end else begin
      send_byte(d);
    end
  endtask

  // Frame of n decoded bytes whose last byte is the xor of the rest,
  // optionally spoiled, closed by an end byte.
  task automatic send_checked_frame(input int n, input bit corrupt, input int esc_pct);
    logic [7:0] d;
    logic [7:0] chk;
    int k;
    chk = 8'h00;
    for (k = 0; k < n - 1; k++) begin
      d = 8'($urandom);
      while (!(plain_ok(d) || escape_ok(d))) d = d + 8'd1;
      send_decoded(d, esc_pct);
      chk ^= d;
    end
    if (n > 0 && corrupt) chk ^= 8'($urandom_range(1, 255));
    if (n > 0 && cfg_esc != cfg_end && chk == (cfg_end ^ cfg_mask) &&
        (!plain_ok(chk) || $urandom_range(0, 1) == 1)) begin
      // escape then end: the masked end byte is the checksum
      send_byte(cfg_esc);
      send_byte(cfg_end);
    end else begin
      if (n > 0) send_decoded(chk, esc_pct);
      send_byte(cfg_end);
    end
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return cfg_end;
      1:       return cfg_esc;
      default: return 8'($urandom);
    endcase
  endfunction

  // A full frame's worth of raw bytes with no end byte: forces a flush.
  task automatic send_overflow_run();
    logic [7:0] b;
    repeat (MAX_FRAME) begin
      b = ($urandom_range(0, 3) == 0) ? cfg_esc : 8'($urandom);
      if (b == cfg_end) b = ~b;
      send_byte(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    gap_pct   = 0;
    stall_pct = 0;
    send_byte(cfg_end);                           // empty frame
    send_byte(8'h00); send_byte(cfg_end);         // one byte, zero: good
    send_byte(8'hFF); send_byte(cfg_end);         // one byte, nonzero: checksum error
    send_byte(cfg_esc); send_byte(cfg_end);       // end with escape pending
    // escape after escape decodes as masked escape char, then its checksum
    send_byte(cfg_esc); send_byte(cfg_esc);
    send_byte(cfg_esc ^ cfg_mask); send_byte(cfg_end);
    // escaped end char and escaped escape char inside the data
    send_byte(cfg_esc); send_byte(cfg_end ^ cfg_mask);
    send_byte(cfg_esc); send_byte(cfg_esc ^ cfg_mask);
    send_byte(cfg_end ^ cfg_esc); send_byte(cfg_end);
    // extreme values
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF); send_byte(cfg_end);
    // checksum carried by escape + end
    send_byte(cfg_end ^ cfg_mask); send_byte(cfg_esc); send_byte(cfg_end);
  endtask

  // Largest good frame: end byte arrives exactly at the raw limit.
  task automatic test_longest_frame();
    logic [7:0] frame_bytes [STORE_DEPTH];
    logic [7:0] chk;
    int k;
    gap_pct   = 20;
    stall_pct = 20;
    chk = 8'h00;
    for (k = 0; k < STORE_DEPTH - 2; k++) begin
      do frame_bytes[k] = 8'($urandom); while (!plain_ok(frame_bytes[k]));
      chk ^= frame_bytes[k];
    end
    do frame_bytes[STORE_DEPTH-2] = 8'($urandom);
    while (!plain_ok(frame_bytes[STORE_DEPTH-2]) ||
           !plain_ok(chk ^ frame_bytes[STORE_DEPTH-2]));
    frame_bytes[STORE_DEPTH-1] = chk ^ frame_bytes[STORE_DEPTH-2];
    for (k = 0; k < STORE_DEPTH; k++) send_byte(frame_bytes[k]);
    send_byte(cfg_end);
  endtask

  task automatic test_overflow();
    gap_pct   = 15;
    stall_pct = 30;
    send_overflow_run();
    send_byte(8'h5A);   // frame after a flush starts clean
    send_byte(8'h5A);
    send_byte(cfg_end);
  endtask

  // Mostly well-formed frames with random content, plus noise and flushes.
  task automatic test_random_frames(input int budget, input int gap, input int stall);
    int first;
    int pick;
    int k;
    int n;
    first     = sent_count;
    stall_pct = stall;
    while (sent_count - first < budget) begin
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : gap;
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        k = $urandom_range(0, 99);
        n = (k < 5) ? 0 : (k < 85) ? $urandom_range(1, 8) : $urandom_range(9, 30);
        send_checked_frame(n, $urandom_range(0, 6) == 0, 30);
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 10)) send_byte(noise_byte());
      end else begin
        send_overflow_run();
      end
    end
    send_byte(cfg_end);   // leave no partial frame behind
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall bursts, started at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted item against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    deframed_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_items.size() == 0) begin
        report_mismatch("unexpected item, out_byte", out_byte, -1);
      end else begin
        want = expected_items.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", out_byte, want.data);
        if (frame_last !== want.last)
          report_mismatch("frame_last", frame_last, want.last);
        if (frame_status !== want.status)
          report_mismatch("frame_status", frame_status, want.status);
      end
      result_count++;
    end
  end

  // Watchdog: too long with nothing moving on any port ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values
    test_directed_cases();
    test_longest_frame();
    test_overflow();
    test_random_frames(25, 25, 25);

    // extremes: end 0x00, escape 0xFF, full mask
    write_reg(REG_END_CHAR, 8'h00);
    write_reg(REG_ESCAPE_CHAR, 8'hFF);
    write_reg(REG_ESCAPE_MASK, 8'hFF);
    test_random_frames(20, 25, 25);

    // opposite extremes, zero mask: escaped bytes pass unchanged
    write_reg(REG_END_CHAR, 8'hFF);
    write_reg(REG_ESCAPE_CHAR, 8'h00);
    write_reg(REG_ESCAPE_MASK, 8'h00);
    test_random_frames(20, 30, 15);

    // end and escape equal: end wins, escapes never start
    write_reg(REG_END_CHAR, 8'h55);
    write_reg(REG_ESCAPE_CHAR, 8'h55);
    write_reg(REG_ESCAPE_MASK, 8'h0F);
    test_random_frames(20, 20, 30);

    // random settings; a write to the unused index changes nothing
    write_reg(REG_END_CHAR, 8'($urandom));
    write_reg(REG_ESCAPE_CHAR, 8'($urandom));
    write_reg(REG_ESCAPE_MASK, 8'($urandom));
    write_reg(REG_UNUSED, 8'($urandom));
    test_random_frames(20, 25, 25);

    // back to reset values, no idling on either side
    write_reg(REG_END_CHAR, END_CHAR_RESET);
    write_reg(REG_ESCAPE_CHAR, ESCAPE_CHAR_RESET);
    write_reg(REG_ESCAPE_MASK, ESCAPE_MASK_RESET);
    test_random_frames(35, 0, 0);

    in_valid <= 1'b0;
    drain_results();
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bsfd_pkg.sv
hw/rtl/byte_stuffed_frame_deframer.sv
verif/testbench.sv
